// ===== hw/rtl/ipv4hc_pkg.sv =====
// shared types, constants and helpers of the ipv4 receive header check
package ipv4hc_pkg;

  // header geometry
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned PosWidth   = 5;
  localparam logic [PosWidth-1:0] LastPos = PosWidth'(HdrBytes - 1);
  localparam logic [15:0] HdrBytes16 = 16'(HdrBytes);

  // header byte positions of interest
  localparam logic [PosWidth-1:0] PosVerIhl   = 5'd0;
  localparam logic [PosWidth-1:0] PosTotLenLo = 5'd3;
  localparam logic [PosWidth-1:0] PosIdentLo  = 5'd5;
  localparam logic [PosWidth-1:0] PosFlagsLo  = 5'd7;
  localparam logic [PosWidth-1:0] PosProto    = 5'd9;
  localparam logic [PosWidth-1:0] PosSrcFirst = 5'd12;
  localparam logic [PosWidth-1:0] PosSrcLast  = 5'd15;
  localparam logic [PosWidth-1:0] PosDstFirst = 5'd16;

  // field constants
  localparam logic [3:0]  Ipv4Version = 4'd4;
  localparam logic [3:0]  BasicIhl    = 4'd5;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] FragMask    = 16'h3fff;
  localparam logic [15:0] OffsetMask  = 16'h1fff;
  localparam logic [15:0] CsumGood    = 16'hffff;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // verdict codes
  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_SHORT    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_IHL      = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CHECKSUM = 3'd5,
    ST_DEST     = 3'd6,
    ST_PROTO    = 3'd7
  } status_e;

  // one collected header, handed from front to back
  typedef struct packed {
    logic [15:0] buf_len;
    logic        ver_ok;
    logic        ihl_ok;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] flags;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] csum;
  } hdr_rec_t;

  // front status seen by the top level
  typedef struct packed {
    logic active;
    logic at_last;
  } front_stat_t;

  // ones-complement 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== hw/rtl/ipv4hc_front.sv =====
// front part: takes header bytes, sums the checksum and collects the fields
module ipv4hc_front import ipv4hc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  header_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] buffer_length_i,
  output logic        push_o,
  output hdr_rec_t    rec_o,
  output front_stat_t stat_o
);

  logic                active_q, active_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [15:0]         sum_q, sum_d;
  logic [7:0]          hi_q, hi_d;
  logic                ver_ok_q, ver_ok_d;
  logic                ihl_ok_q, ihl_ok_d;
  logic [15:0]         buf_q, buf_d;
  logic [15:0]         tl_q, tl_d;
  logic [15:0]         id_q, id_d;
  logic [15:0]         fl_q, fl_d;
  logic [7:0]          proto_q, proto_d;
  logic [31:0]         src_q, src_d;
  logic [31:0]         dst_q, dst_d;

  logic                take;
  logic [PosWidth-1:0] pos_eff;
  logic [15:0]         sum_base;
  logic [15:0]         word;

  // a byte counts when it opens a packet or one is open
  assign take     = accept_i && (first_byte_i || active_q);
  assign pos_eff  = first_byte_i ? '0 : pos_q;
  assign sum_base = first_byte_i ? 16'd0 : sum_q;
  assign word     = {hi_q, header_byte_i};

  // per-byte field capture and checksum
  always_comb begin
    active_d = active_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    hi_d     = hi_q;
    ver_ok_d = ver_ok_q;
    ihl_ok_d = ihl_ok_q;
    buf_d    = buf_q;
    tl_d     = tl_q;
    id_d     = id_q;
    fl_d     = fl_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    push_o   = 1'b0;
    if (take) begin
      if (first_byte_i) begin
        buf_d = buffer_length_i;
      end
      if (pos_eff[0] == 1'b0) begin
        hi_d  = header_byte_i;
        sum_d = sum_base;
      end else begin
        sum_d = ones_add(sum_base, word);
      end
      case (pos_eff)
        PosVerIhl: begin
          ver_ok_d = (header_byte_i[7:4] == Ipv4Version);
          ihl_ok_d = (header_byte_i[3:0] == BasicIhl);
        end
        PosTotLenLo: tl_d    = word;
        PosIdentLo:  id_d    = word;
        PosFlagsLo:  fl_d    = word;
        PosProto:    proto_d = header_byte_i;
        default: begin
          if (pos_eff >= PosSrcFirst && pos_eff <= PosSrcLast) begin
            src_d = {src_q[23:0], header_byte_i};
          end else if (pos_eff >= PosDstFirst) begin
            dst_d = {dst_q[23:0], header_byte_i};
          end
        end
      endcase
      if (pos_eff == LastPos) begin
        push_o   = 1'b1;
        active_d = 1'b0;
        pos_d    = '0;
      end else begin
        active_d = 1'b1;
        pos_d    = pos_eff + 1'b1;
      end
    end
  end

  // record handed to the queue on the last byte
  always_comb begin
    rec_o.buf_len   = buf_q;
    rec_o.ver_ok    = ver_ok_q;
    rec_o.ihl_ok    = ihl_ok_q;
    rec_o.total_len = tl_q;
    rec_o.ident     = id_q;
    rec_o.flags     = fl_q;
    rec_o.proto     = proto_q;
    rec_o.src       = src_q;
    rec_o.dst       = dst_d;
    rec_o.csum      = sum_d;
  end

  assign stat_o.active  = active_q;
  assign stat_o.at_last = (pos_q == LastPos);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
    end
  end

  // header fields
  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    hi_q     <= hi_d;
    ver_ok_q <= ver_ok_d;
    ihl_ok_q <= ihl_ok_d;
    buf_q    <= buf_d;
    tl_q     <= tl_d;
    id_q     <= id_d;
    fl_q     <= fl_d;
    proto_q  <= proto_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
  end

endmodule

// ===== hw/rtl/ipv4hc_queue.sv =====
// short queue of collected headers between front and back
module ipv4hc_queue import ipv4hc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hdr_rec_t wdata_i,
  input  logic     pop_i,
  output hdr_rec_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hdr_rec_t             mem_q [Depth];
  logic [AddrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer advance with wrap at any depth
  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p);
    return (p == AddrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/ipv4hc_back.sv =====
// back part: runs the header checks and holds the verdict beat
module ipv4hc_back import ipv4hc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hdr_rec_t    rec_i,
  input  logic        empty_i,
  output logic        pop_o,
  input  logic [31:0] local_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  protocol_number_o,
  output logic [31:0] source_address_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] padding_bytes_o,
  output logic        is_fragment_o,
  output logic        more_fragments_o,
  output logic [12:0] fragment_offset_o,
  output logic [15:0] packet_id_o
);

  logic        valid_q;
  status_e     status_d, status_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [15:0] payload_d, payload_q;
  logic [15:0] padding_d, padding_q;
  logic        frag_q, mf_q;
  logic [12:0] offset_q;
  logic [15:0] id_q;
  logic        proto_known;

  // take the next header when the output slot is free or being drained
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  assign proto_known = (rec_i.proto == ProtoTcp) || (rec_i.proto == ProtoIcmp) ||
                       (rec_i.proto == ProtoUdp);

  // checks in priority order, first failure wins
  always_comb begin
    if (rec_i.buf_len < HdrBytes16) begin
      status_d = ST_SHORT;
    end else if (!rec_i.ver_ok) begin
      status_d = ST_VERSION;
    end else if (!rec_i.ihl_ok) begin
      status_d = ST_IHL;
    end else if (rec_i.total_len > rec_i.buf_len) begin
      status_d = ST_LENGTH;
    end else if (rec_i.csum != CsumGood) begin
      status_d = ST_CHECKSUM;
    end else if (rec_i.dst != local_address_i) begin
      status_d = ST_DEST;
    end else if (!proto_known) begin
      status_d = ST_PROTO;
    end else begin
      status_d = ST_ACCEPT;
    end
  end

  // lengths clamp at zero
  assign payload_d = (rec_i.total_len >= HdrBytes16) ? rec_i.total_len - HdrBytes16 : 16'd0;
  assign padding_d = (rec_i.buf_len >= rec_i.total_len) ? rec_i.buf_len - rec_i.total_len
                                                        : 16'd0;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // verdict payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      proto_q   <= rec_i.proto;
      src_q     <= rec_i.src;
      payload_q <= payload_d;
      padding_q <= padding_d;
      frag_q    <= (rec_i.flags & FragMask) != 16'd0;
      mf_q      <= rec_i.flags[13];
      offset_q  <= rec_i.flags[12:0] & OffsetMask[12:0];
      id_q      <= rec_i.ident;
    end
  end

  assign out_valid_o       = valid_q;
  assign status_o          = status_q;
  assign protocol_number_o = proto_q;
  assign source_address_o  = src_q;
  assign payload_length_o  = payload_q;
  assign padding_bytes_o   = padding_q;
  assign is_fragment_o     = frag_q;
  assign more_fragments_o  = mf_q;
  assign fragment_offset_o = offset_q;
  assign packet_id_o       = id_q;

endmodule

// ===== hw/rtl/ipv4_rx_header_check_top.sv =====
// top level of the ipv4 receive header check
// Takes the 20 header bytes of a received IPv4 packet at one byte per cycle and
// gives one verdict beat per complete header: status, protocol, source, payload
// length, padding to trim and fragment fields. Bytes are taken back to back with
// no gaps; the front part sums the checksum and captures fields byte by byte,
// and the verdict appears once it has passed the header queue and the output
// register of the back part. The input stalls only on a twentieth byte while
// the header queue (FifoDepth entries) is full, which happens only when the
// output side has stalled long enough to back up that many verdicts. A byte
// with no packet open and without the first byte flag is dropped; a first byte
// inside an open packet drops that packet. The user writes local_address via
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not check.
module ipv4_rx_header_check_top import ipv4hc_pkg::*; #(
  parameter int unsigned FifoDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] buffer_length_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  protocol_number_o,
  output logic [31:0] source_address_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] padding_bytes_o,
  output logic        is_fragment_o,
  output logic        more_fragments_o,
  output logic [12:0] fragment_offset_o,
  output logic [15:0] packet_id_o
);

  logic [31:0] local_address_q;
  logic        in_accept;
  logic        rec_push, rec_pop;
  hdr_rec_t    rec_w, rec_r;
  logic        q_full, q_empty;
  front_stat_t front_stat;

  // local address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_address_q <= '0;
    end else if (cfg_we_i) begin
      local_address_q <= cfg_wdata_i;
    end
  end

  // hold a completing byte only while the queue has no room
  assign in_stall_o = q_full && front_stat.active && front_stat.at_last && !first_byte_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  ipv4hc_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (in_accept),
    .header_byte_i,
    .first_byte_i,
    .buffer_length_i,
    .push_o          (rec_push),
    .rec_o           (rec_w),
    .stat_o          (front_stat)
  );

  ipv4hc_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (rec_push),
    .wdata_i (rec_w),
    .pop_i   (rec_pop),
    .rdata_o (rec_r),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ipv4hc_back u_back (
    .clk_i,
    .rst_ni,
    .rec_i           (rec_r),
    .empty_i         (q_empty),
    .pop_o           (rec_pop),
    .local_address_i (local_address_q),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .protocol_number_o,
    .source_address_o,
    .payload_length_o,
    .padding_bytes_o,
    .is_fragment_o,
    .more_fragments_o,
    .fragment_offset_o,
    .packet_id_o
  );

  // no header is ever pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_push && q_full))
    else $error("header pushed into full queue");

  // a completing byte always lands a header in the queue
  a_last_byte_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !first_byte_i && front_stat.active && front_stat.at_last) |=> !q_empty)
    else $error("completed header missing from queue");

  // a waiting header reaches a free output slot in the next cycle
  a_back_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && !out_valid_o) |=> out_valid_o)
    else $error("back part did not take a waiting header");

endmodule

// ===== dv/ipv4_rx_header_check_top_test.sv =====
// self-checking testbench of the ipv4 receive header check top level
`timescale 1ns / 100ps

module ipv4_rx_header_check_top_test;
  import ipv4hc_pkg::*;

  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 6;
  localparam logic [31:0] DirAddr      = 32'hC0A8_0A01;
  localparam logic [4:0]  LastBytePos  = 5'd19;
  localparam logic [15:0] MinHdrLen    = 16'd20;

  // one verdict beat as seen on the output
  typedef struct {
    status_e     status;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [15:0] payload;
    logic [15:0] padding;
    logic        frag;
    logic        mf;
    logic [12:0] offset;
    logic [15:0] ident;
  } verdict_t;

  // one directed header, status typed in where it is obvious
  typedef struct {
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] flags;
    logic [7:0]  proto;
    logic [31:0] dst;
    logic [15:0] buf_len;
    bit          bad_csum;
    bit          lead_first;
    int          n_bytes;
    bit          typed;
    status_e     status;
  } dir_row_t;

  dir_row_t dir_tbl [18] = '{
    '{8'h45, 16'd60,    16'h0000, ProtoTcp,  DirAddr,       16'd64,    1'b0, 1'b1, 20, 1'b1, ST_ACCEPT},
    '{8'h45, 16'd20,    16'h4000, ProtoIcmp, DirAddr,       16'd20,    1'b0, 1'b1, 20, 1'b1, ST_ACCEPT},
    '{8'h45, 16'd576,   16'h2000, ProtoUdp,  DirAddr,       16'd1500,  1'b0, 1'b1, 20, 1'b1, ST_ACCEPT},
    '{8'h45, 16'd1500,  16'hFFFF, ProtoUdp,  DirAddr,       16'd1500,  1'b0, 1'b1, 20, 1'b1, ST_ACCEPT},
    '{8'h45, 16'd65535, 16'h1FFF, ProtoTcp,  DirAddr,       16'd65535, 1'b0, 1'b1, 20, 1'b1, ST_ACCEPT},
    '{8'h45, 16'd20,    16'h0000, ProtoTcp,  DirAddr,       16'd19,    1'b0, 1'b1, 20, 1'b1, ST_SHORT},
    '{8'h00, 16'd0,     16'h0000, 8'h00,     32'h0000_0000, 16'd0,     1'b1, 1'b1, 20, 1'b1, ST_SHORT},
    '{8'h65, 16'd40,    16'h0000, ProtoTcp,  DirAddr,       16'd40,    1'b0, 1'b1, 20, 1'b1, ST_VERSION},
    '{8'hFF, 16'hFFFF,  16'hFFFF, 8'hFF,     32'hFFFF_FFFF, 16'd20,    1'b0, 1'b1, 20, 1'b1, ST_VERSION},
    '{8'h46, 16'd40,    16'h0000, ProtoTcp,  DirAddr,       16'd40,    1'b0, 1'b1, 20, 1'b1, ST_IHL},
    '{8'h45, 16'd1500,  16'h0000, ProtoTcp,  DirAddr,       16'd100,   1'b0, 1'b1, 20, 1'b1, ST_LENGTH},
    '{8'h45, 16'd100,   16'h0000, ProtoTcp,  DirAddr,       16'd100,   1'b1, 1'b1, 20, 1'b1, ST_CHECKSUM},
    '{8'h45, 16'd100,   16'h0000, ProtoTcp,  32'hC0A8_0A02, 16'd100,   1'b0, 1'b1, 20, 1'b1, ST_DEST},
    '{8'h45, 16'd100,   16'h0000, 8'h02,     DirAddr,       16'd100,   1'b0, 1'b1, 20, 1'b1, ST_PROTO},
    '{8'h45, 16'd0,     16'h0000, 8'hFF,     DirAddr,       16'd40,    1'b0, 1'b1, 20, 1'b1, ST_PROTO},
    '{8'h45, 16'd40,    16'h0000, ProtoTcp,  DirAddr,       16'd40,    1'b0, 1'b0, 3,  1'b0, ST_ACCEPT},
    '{8'h45, 16'd40,    16'h0000, ProtoTcp,  DirAddr,       16'd40,    1'b0, 1'b1, 9,  1'b0, ST_ACCEPT},
    '{8'h45, 16'd48,    16'h0000, ProtoUdp,  DirAddr,       16'd48,    1'b0, 1'b1, 20, 1'b1, ST_ACCEPT}
  };

  // dut signals, all inputs known from time zero
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  header_byte   = 8'h00;
  logic        first_byte    = 1'b0;
  logic [15:0] buffer_length = 16'h0000;
  logic        cfg_we        = 1'b0;
  logic [31:0] cfg_wdata     = 32'h0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_proto;
  logic [31:0] out_src;
  logic [15:0] out_payload;
  logic [15:0] out_padding;
  logic        out_frag;
  logic        out_mf;
  logic [12:0] out_offset;
  logic [15:0] out_ident;

  // handshake pacing and bookkeeping
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;
  int unsigned beats_seen     = 0;
  int unsigned bytes_taken    = 0;
  int unsigned verdicts_made  = 0;
  verdict_t    verdict_q [$];

  // header parser shadow state
  logic [31:0] local_addr_m;
  logic [4:0]  m_pos;
  logic        m_open;
  logic [15:0] m_csum;
  logic [7:0]  m_hi;
  logic        m_ver_ok;
  logic        m_ihl_ok;
  logic [15:0] m_buf_len;
  logic [15:0] m_tot_len;
  logic [15:0] m_ident;
  logic [15:0] m_flags;
  logic [7:0]  m_proto;
  logic [31:0] m_src;
  logic [31:0] m_dst;
  bit          pin_status_en = 1'b0;
  status_e     pin_status    = ST_ACCEPT;

  ipv4_rx_header_check_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .header_byte_i     (header_byte),
    .first_byte_i      (first_byte),
    .buffer_length_i   (buffer_length),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (out_status),
    .protocol_number_o (out_proto),
    .source_address_o  (out_src),
    .payload_length_o  (out_payload),
    .padding_bytes_o   (out_padding),
    .is_fragment_o     (out_frag),
    .more_fragments_o  (out_mf),
    .fragment_offset_o (out_offset),
    .packet_id_o       (out_ident)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // end-around carry add of two 16-bit words
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    int unsigned t;
    t = a + b;
    if (t > 32'h0000_FFFF) t = t - 32'h0000_FFFF;
    return t[15:0];
  endfunction

  // 20-byte header with the checksum filled in, optionally spoiled by flip
  function automatic logic [159:0] make_header(
    input logic [7:0] ver_ihl, input logic [7:0] tos, input logic [15:0] tot_len,
    input logic [15:0] ident, input logic [15:0] flags, input logic [7:0] ttl,
    input logic [7:0] proto, input logic [31:0] src, input logic [31:0] dst,
    input logic [15:0] flip);
    logic [159:0] h;
    logic [15:0]  s;
    h = {ver_ihl, tos, tot_len, ident, flags, ttl, proto, 16'h0000, src, dst};
    s = 16'h0000;
    for (int i = 0; i < 10; i++) s = fold_add(s, h[159 - 16*i -: 16]);
    h[79:64] = ~s ^ flip;
    return h;
  endfunction

  task automatic clear_parser();
    m_pos     = 5'd0;
    m_csum    = 16'h0000;
    m_hi      = 8'h00;
    m_ver_ok  = 1'b0;
    m_ihl_ok  = 1'b0;
    m_tot_len = 16'h0000;
    m_ident   = 16'h0000;
    m_flags   = 16'h0000;
    m_proto   = 8'h00;
    m_src     = 32'h0;
    m_dst     = 32'h0;
  endtask

  // advance the shadow parser by one accepted byte, queue a verdict on the last
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic [15:0] blen,
                            output bit consumed, output bit produced);
    logic [15:0] word;
    verdict_t    v;
    consumed = 1'b0;
    produced = 1'b0;
    if (first) begin
      clear_parser();
      m_open    = 1'b1;
      m_buf_len = blen;
    end else if (!m_open) begin
      return;
    end
    consumed = 1'b1;

    // checksum and word-wide fields on every odd byte
    if (!m_pos[0]) begin
      m_hi = b;
    end else begin
      word   = {m_hi, b};
      m_csum = fold_add(m_csum, word);
      case (m_pos)
        5'd3: m_tot_len = word;
        5'd5: m_ident   = word;
        5'd7: m_flags   = word;
        default: ;
      endcase
    end

    // byte-wide fields
    if (m_pos == 5'd0) begin
      m_ver_ok = (b[7:4] == 4'd4);
      m_ihl_ok = (b[3:0] == 4'd5);
    end else if (m_pos == 5'd9) begin
      m_proto = b;
    end else if (m_pos >= 5'd12 && m_pos <= 5'd15) begin
      m_src = {m_src[23:0], b};
    end else if (m_pos >= 5'd16) begin
      m_dst = {m_dst[23:0], b};
    end

    if (m_pos != LastBytePos) begin
      m_pos = m_pos + 5'd1;
      return;
    end

    // verdict, first failing check wins
    if (m_buf_len < MinHdrLen) v.status = ST_SHORT;
    else if (!m_ver_ok) v.status = ST_VERSION;
    else if (!m_ihl_ok) v.status = ST_IHL;
    else if (m_tot_len > m_buf_len) v.status = ST_LENGTH;
    else if (m_csum != 16'hFFFF) v.status = ST_CHECKSUM;
    else if (m_dst != local_addr_m) v.status = ST_DEST;
    else if (m_proto != ProtoTcp && m_proto != ProtoIcmp && m_proto != ProtoUdp)
      v.status = ST_PROTO;
    else v.status = ST_ACCEPT;
    if (pin_status_en) v.status = pin_status;

    v.proto   = m_proto;
    v.src     = m_src;
    v.payload = (m_tot_len >= MinHdrLen) ? m_tot_len - MinHdrLen : 16'h0000;
    v.padding = (m_buf_len >= m_tot_len) ? m_buf_len - m_tot_len : 16'h0000;
    v.frag    = |m_flags[13:0];
    v.mf      = m_flags[13];
    v.offset  = m_flags[12:0];
    v.ident   = m_ident;
    verdict_q.push_back(v);
    produced = 1'b1;
    m_open   = 1'b0;
    clear_parser();
  endtask

  // present one byte beat, hold it until taken, then update the shadow parser
  task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] blen);
    bit consumed;
    bit produced;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    header_byte   <= b;
    first_byte    <= first;
    buffer_length <= blen;
    do @(posedge clk); while (in_stall);
    parse_byte(b, first, blen, consumed, produced);
    if (consumed) bytes_taken++;
    if (produced) verdicts_made++;
  endtask

  task automatic send_header(input logic [159:0] hdr, input logic [15:0] blen,
                             input int n, input logic lead_first);
    for (int i = 0; i < n; i++)
      send_byte(hdr[159 - 8*i -: 8], lead_first && (i == 0), (i == 0) ? blen : 16'($urandom));
  endtask

  // hold off the sender until every queued verdict has come out
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  task automatic write_local_addr(input logic [31:0] addr);
    drain_verdicts();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we       <= 1'b0;
    local_addr_m  = addr;
  endtask

  // mostly well-formed headers with random content, some broken or cut short
  task automatic send_random_header();
    logic [15:0] blen;
    logic [15:0] tlen;
    logic [15:0] flags;
    logic [15:0] flip;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [31:0] dst;
    int unsigned pick;
    int          n;
    pick = $urandom_range(0, 99);
    if (pick < 5) blen = 16'($urandom_range(0, 19));
    else if (pick < 20) blen = 16'($urandom);
    else blen = 16'($urandom_range(20, 2000));
    if ($urandom_range(0, 99) < 85 && blen >= MinHdrLen) tlen = 16'($urandom_range(20, blen));
    else tlen = 16'($urandom);
    vihl  = ($urandom_range(0, 99) < 90) ? 8'h45 : 8'($urandom);
    flags = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
    case ($urandom_range(0, 4))
      0: proto = ProtoIcmp;
      1: proto = ProtoTcp;
      2: proto = ProtoUdp;
      3: proto = ProtoTcp;
      default: proto = 8'($urandom);
    endcase
    dst  = ($urandom_range(0, 99) < 85) ? local_addr_m : $urandom;
    flip = ($urandom_range(0, 99) < 90) ? 16'h0000 : 16'($urandom);
    n    = ($urandom_range(0, 99) < 92) ? 20 : int'($urandom_range(1, 19));
    send_header(make_header(vihl, 8'($urandom), tlen, 16'($urandom), flags, 8'($urandom),
                            proto, $urandom, dst, flip), blen, n, 1'b1);
  endtask

  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input logic [31:0] addr, input int unsigned byte_goal,
                           input int unsigned verdict_goal);
    int unsigned bytes_at;
    int unsigned verdicts_at;
    write_local_addr(addr);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    bytes_at       = bytes_taken;
    verdicts_at    = verdicts_made;
    while (bytes_taken - bytes_at < byte_goal || verdicts_made - verdicts_at < verdict_goal) begin
      if ($urandom_range(0, 15) == 0) drain_verdicts();
      // stray bytes without the first flag: dropped when idle, continue an open header
      if ($urandom_range(0, 99) < 6)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 16'($urandom));
      send_random_header();
    end
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("%0t ns beat %0d mismatch: %s", $time, beats_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // verdict beats against the oldest prediction
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_seen++;
      if (verdict_q.size() == 0) begin
        log_mismatch("verdict beat with nothing expected");
      end else begin
        want = verdict_q.pop_front();
        check_field("status", 32'(out_status), 32'(want.status));
        check_field("protocol", 32'(out_proto), 32'(want.proto));
        check_field("source", out_src, want.src);
        check_field("payload_length", 32'(out_payload), 32'(want.payload));
        check_field("padding", 32'(out_padding), 32'(want.padding));
        check_field("is_fragment", 32'(out_frag), 32'(want.frag));
        check_field("more_fragments", 32'(out_mf), 32'(want.mf));
        check_field("fragment_offset", 32'(out_offset), 32'(want.offset));
        check_field("packet_id", 32'(out_ident), 32'(want.ident));
      end
    end
  end

  // cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("watchdog: no beat moved for %0d cycles", QuietLimit);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    local_addr_m = 32'h0;
    m_open       = 1'b0;
    m_buf_len    = 16'h0000;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed headers: each check, precedence, idle and cut-short cases
    write_local_addr(DirAddr);
    foreach (dir_tbl[i]) begin
      pin_status_en = dir_tbl[i].typed;
      pin_status    = dir_tbl[i].status;
      send_header(make_header(dir_tbl[i].ver_ihl, 8'h00, dir_tbl[i].tot_len, 16'hFF00 + 16'(i),
                              dir_tbl[i].flags, 8'd64, dir_tbl[i].proto, 32'h0A00_0000 + i,
                              dir_tbl[i].dst, dir_tbl[i].bad_csum ? 16'h0001 : 16'h0000),
                  dir_tbl[i].buf_len, dir_tbl[i].n_bytes, dir_tbl[i].lead_first);
      pin_status_en = 1'b0;
    end

    // random headers under three pacing mixes and address settings
    run_phase(10, 85, 32'hFFFF_FFFF, 230, 8);
    run_phase(85, 10, 32'h0000_0000, 230, 8);
    run_phase(0, 0, $urandom, 230, 8);

    drain_verdicts();
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
